// ===== rtl/rue_pkg.sv =====
// shared types, opcodes and constants for the risc execute unit
`default_nettype none

package rue_pkg;

    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned IDX_W     = $clog2(REG_COUNT);

    localparam logic [3:0] OP_LD   = 4'd0;
    localparam logic [3:0] OP_ST   = 4'd1;
    localparam logic [3:0] OP_STP  = 4'd2;
    localparam logic [3:0] OP_CLS  = 4'd3;
    localparam logic [3:0] OP_BEXT = 4'd4;
    localparam logic [3:0] OP_SBIT = 4'd5;
    localparam logic [3:0] OP_SUB  = 4'd6;
    localparam logic [3:0] OP_ADD  = 4'd7;
    localparam logic [3:0] OP_ADDI = 4'd8;
    localparam logic [3:0] OP_BEQ  = 4'd9;
    localparam logic [3:0] OP_BNE  = 4'd10;
    localparam logic [3:0] OP_J    = 4'd11;
    localparam logic [3:0] OP_SSAT = 4'd12;
    localparam logic [3:0] OP_LRET = 4'd13;

    localparam logic [31:0] PC_STEP        = 32'd4;
    localparam logic [31:0] JUMP_KEEP_MASK = 32'hFFFF_F000;
    localparam logic [1:0]  WORD_ALIGNED   = 2'b00;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [3:0]         op;
        logic [4:0]         field_d;
        logic [4:0]         field_s1;
        logic [4:0]         field_s2;
        logic [4:0]         field_t;
        logic signed [15:0] immediate;
        logic [25:0]        jump_index;
        logic [31:0]        returned_word;
    } instr_t;

    typedef struct packed {
        logic        write_request;
        logic        read_request;
        logic [31:0] access_address;
        logic [31:0] write_word;
        logic [4:0]  load_target;
        logic        taken;
        logic [31:0] new_pc;
        logic        final_res;
    } result_t;

    // register file write-back
    typedef struct packed {
        logic        en;
        idx_t        idx;
        logic [31:0] data;
    } wb_t;

    // operand read addresses
    typedef struct packed {
        idx_t a;
        idx_t b;
        idx_t c;
    } raddr_t;

    // operands: a from field_d, b from field_s1, c from field_s2 or field_t
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } operands_t;

    function automatic idx_t reg_idx(input logic [4:0] f);
        return IDX_W'(32'(f) % REG_COUNT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rue_if.sv =====
// valid/ready channel interfaces for instructions and results
`default_nettype none

interface rue_instr_if import rue_pkg::*; ();
    logic   valid;
    logic   ready;
    instr_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rue_result_if import rue_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rue_regfile.sv =====
// register file: two ram copies for three read ports, valid bits and write bypass
`default_nettype none

module rue_regfile import rue_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      rd_en,
    input  wire raddr_t    raddr,
    input  wire wb_t       wb,
    output operands_t      rdata
);

    logic [31:0]          mem_a_reg [REG_COUNT];
    logic [31:0]          mem_b_reg [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;

    logic [31:0] q_a_reg, q_b_reg, q_c_reg;
    logic [31:0] byp_reg;
    logic        hit_a_reg, hit_b_reg, hit_c_reg;
    logic        v_a_reg, v_b_reg, v_c_reg;

    // both copies take every write
    always_ff @(posedge clk)
    begin
        if (wb.en)
        begin
            mem_a_reg[wb.idx] <= wb.data;
            mem_b_reg[wb.idx] <= wb.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wb.en)
        begin
            vld_reg[wb.idx] <= 1'b1;
        end
    end

    // registered reads; a write on the same edge is caught by the bypass
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_a_reg   <= mem_a_reg[raddr.a];
            q_b_reg   <= mem_a_reg[raddr.b];
            q_c_reg   <= mem_b_reg[raddr.c];
            v_a_reg   <= vld_reg[raddr.a];
            v_b_reg   <= vld_reg[raddr.b];
            v_c_reg   <= vld_reg[raddr.c];
            hit_a_reg <= wb.en && (wb.idx == raddr.a);
            hit_b_reg <= wb.en && (wb.idx == raddr.b);
            hit_c_reg <= wb.en && (wb.idx == raddr.c);
            byp_reg   <= wb.data;
        end
    end

    always_comb
    begin
        rdata.a = hit_a_reg ? byp_reg : (v_a_reg ? q_a_reg : 32'd0);
        rdata.b = hit_b_reg ? byp_reg : (v_b_reg ? q_b_reg : 32'd0);
        rdata.c = hit_c_reg ? byp_reg : (v_c_reg ? q_c_reg : 32'd0);
    end

endmodule

`default_nettype wire

// ===== rtl/rue_exec.sv =====
// execute logic: one result, register write-back and next pc for the staged instruction
`default_nettype none

module rue_exec import rue_pkg::*; (
    input  wire instr_t      item,
    input  wire logic        second,
    input  wire logic [31:0] pc,
    input  wire operands_t   opnd,
    output result_t          res,
    output wb_t              wb,
    output logic [31:0]      pc_next,
    output logic             last
);

    // leading bits equal to the sign bit, 1 to 32
    function automatic logic [31:0] count_sign(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  n;
        x = v ^ {32{v[31]}};
        n = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                n = 6'(31 - i);
            end
        end
        return {26'd0, n};
    endfunction

    function automatic logic [31:0] bit_extract(input logic [31:0] v, input logic [31:0] m);
        logic [31:0] r;
        logic [5:0]  pos;
        r   = '0;
        pos = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
            begin
                r[pos[4:0]] = v[i];
                pos         = pos + 6'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_signed(input logic [31:0] v, input logic [4:0] w);
        logic [31:0] lim;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] r;
        lim = 32'd1 << (w - 5'd1);
        hi  = lim - 32'd1;
        lo  = ~hi;
        if (w == 5'd0)
            r = 32'd0;
        else if ($signed(v) > $signed(hi))
            r = hi;
        else if ($signed(v) < $signed(lo))
            r = lo;
        else
            r = v;
        return r;
    endfunction

    logic [31:0] imm32;
    logic [31:0] addr;
    logic [31:0] pc4;
    logic        is_beq;

    assign imm32  = {{16{item.immediate[15]}}, item.immediate};
    assign addr   = opnd.a + imm32;
    assign pc4    = pc + PC_STEP;
    assign is_beq = (item.op == OP_BEQ);
    assign last   = !((item.op == OP_STP) && !second);

    always_comb
    begin
        res     = '0;
        wb      = '0;
        pc_next = pc4;
        case (item.op)
            OP_LD:
            begin
                res.read_request   = 1'b1;
                res.access_address = addr;
                res.load_target    = item.field_s1;
            end
            OP_ST:
            begin
                // misaligned store is dropped
                if (addr[1:0] == WORD_ALIGNED)
                begin
                    res.write_request  = 1'b1;
                    res.access_address = addr;
                    res.write_word     = opnd.b;
                end
            end
            OP_STP:
            begin
                res.write_request  = 1'b1;
                res.access_address = second ? (addr + PC_STEP) : addr;
                res.write_word     = second ? opnd.c : opnd.b;
            end
            OP_CLS:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_d);
                wb.data = count_sign(opnd.b);
            end
            OP_BEXT:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_d);
                wb.data = bit_extract(opnd.b, opnd.c);
            end
            OP_SBIT:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_d);
                wb.data = 32'd1 << item.field_s2;
            end
            OP_SUB:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_s2);
                wb.data = opnd.a - opnd.b;
            end
            OP_ADD:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_s2);
                wb.data = opnd.a + opnd.b;
            end
            OP_ADDI:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_s1);
                wb.data = addr;
            end
            OP_BEQ, OP_BNE:
            begin
                if ((opnd.a == opnd.c) == is_beq)
                begin
                    pc_next   = pc + {imm32[29:0], 2'b00};
                    res.taken = 1'b1;
                end
            end
            OP_J:
            begin
                pc_next   = (pc & JUMP_KEEP_MASK) | {4'd0, item.jump_index, 2'b00};
                res.taken = 1'b1;
            end
            OP_SSAT:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_d);
                wb.data = sat_signed(opnd.b, item.field_s2);
            end
            OP_LRET:
            begin
                wb.en   = 1'b1;
                wb.idx  = reg_idx(item.field_s1);
                wb.data = item.returned_word;
                pc_next = pc;
            end
            default:
            begin
                pc_next = pc4;
            end
        endcase
        res.new_pc    = pc_next;
        res.final_res = last;
    end

endmodule

`default_nettype wire

// ===== rtl/risc_execute_unit.sv =====
// risc execute unit top level: operand stage, execute, result register and pc
//
// instr carries one decoded instruction per request, result carries the
// results; both are valid/ready channels and a request moves when valid and
// ready are high at a rising clock edge.
// every instruction gives one result, a pair store gives two; the last one of
// an instruction has final_res set.
// an accepted instruction and its register file read are registered in the
// operand stage; execute is combinational and the result register takes the
// first result when free. throughput: one instruction per cycle when the
// receiver does not stall; the result register takes one result per cycle.
// register file writes and the pc update happen when the last result of an
// instruction enters the result register; a write on the same edge as a read
// is forwarded, so dependent instructions issue back to back.
// reset clears the pc, marks every register as zero through valid bits and
// empties both stages.
// when the receiver stalls, the result register holds its request and the
// operand stage holds one more instruction; instr.ready drops when both are
// full, and for one cycle while the first half of a pair store goes out.

`default_nettype none

module risc_execute_unit import rue_pkg::*; (
    input wire logic         clk,
    input wire logic         rst_n,
    rue_instr_if.sink        instr,
    rue_result_if.source     result
);

    logic        s_vld_reg;
    logic        s_second_reg;
    instr_t      s_item_reg;
    logic        o_vld_reg;
    result_t     o_res_reg;
    logic [31:0] pc_reg;

    logic        o_ready;
    logic        s_fire;
    logic        s_last;
    logic        in_fire;
    logic        commit;
    raddr_t      raddr;
    operands_t   opnd;
    result_t     res;
    wb_t         ex_wb;
    wb_t         wb;
    logic [31:0] pc_next;

    assign o_ready     = !o_vld_reg || result.ready;
    assign s_fire      = s_vld_reg && o_ready;
    assign commit      = s_fire && s_last;
    assign instr.ready = !s_vld_reg || commit;
    assign in_fire     = instr.valid && instr.ready;

    always_comb
    begin
        raddr.a = reg_idx(instr.data.field_d);
        raddr.b = reg_idx(instr.data.field_s1);
        raddr.c = ((instr.data.op == OP_BEQ) || (instr.data.op == OP_BNE))
                  ? reg_idx(instr.data.field_t) : reg_idx(instr.data.field_s2);
        wb      = ex_wb;
        wb.en   = ex_wb.en && commit;
    end

    rue_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (in_fire),
        .raddr (raddr),
        .wb    (wb),
        .rdata (opnd)
    );

    rue_exec u_exec (
        .item    (s_item_reg),
        .second  (s_second_reg),
        .pc      (pc_reg),
        .opnd    (opnd),
        .res     (res),
        .wb      (ex_wb),
        .pc_next (pc_next),
        .last    (s_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg    <= 1'b0;
            s_second_reg <= 1'b0;
            o_vld_reg    <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            if (in_fire)
                s_vld_reg <= 1'b1;
            else if (commit)
                s_vld_reg <= 1'b0;

            if (s_fire)
                s_second_reg <= !s_last;

            if (o_ready)
                o_vld_reg <= s_vld_reg;

            if (commit)
                pc_reg <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s_item_reg <= instr.data;
        if (s_fire)
            o_res_reg <= res;
    end

    assign result.valid = o_vld_reg;
    assign result.data  = o_res_reg;

endmodule

`default_nettype wire

// ===== rtl/rue_checker.sv =====
// port-level assertions for the risc execute unit and their bind
`default_nettype none

module rue_checker import rue_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    res_valid,
    input wire logic    res_ready,
    input wire result_t res_data
);

    // a result is never both a read and a write
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.write_request && res_data.read_request))
        else $error("result is both read and write request");

    // a taken branch or jump carries no memory access
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.taken) |-> (!res_data.write_request && !res_data.read_request))
        else $error("taken result carries a memory access");

    // a load gives a single result with no write data
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.read_request)
            |-> (res_data.final_res && (res_data.write_word == 32'd0)))
        else $error("load request malformed");

    // first half of a pair store is followed at once by the second word write
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res_data.final_res)
            |=> (res_valid && res_data.final_res && res_data.write_request
                 && (res_data.access_address == $past(res_data.access_address) + PC_STEP)))
        else $error("pair store second write missing or misplaced");

    // stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("stalled result request changed");

endmodule

bind risc_execute_unit rue_checker u_rue_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

`default_nettype wire

// ===== verif/risc_execute_unit_test.sv =====
`timescale 1ns / 100ps
// testbench for the risc execute unit: directed and random instruction streams checked per result

module risc_execute_unit_test import rue_pkg::*; ();

    // opcodes with no defined instruction, executed as a plain pc step
    localparam logic [3:0] OP_SPARE_A = 4'd14;
    localparam logic [3:0] OP_SPARE_B = 4'd15;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;

    rue_instr_if  instr_ch ();
    rue_result_if result_ch ();

    risc_execute_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    logic [31:0] model_regs [REG_COUNT];
    logic [31:0] model_pc;
    result_t     expected_results [$];
    logic [4:0]  open_loads [$];
    bit          gaps_on;

    int unsigned mismatch_count;
    int unsigned instr_count;
    int unsigned result_count;
    int unsigned read_count;
    int unsigned write_count;
    int unsigned taken_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] count_sign_run(input logic [31:0] v);
        logic [31:0] n;
        n = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i] != v[31])
                break;
            n++;
        end
        return n;
    endfunction

    function automatic logic [31:0] gather_masked_bits(input logic [31:0] v,
                                                       input logic [31:0] mask);
        logic [31:0] r;
        int pos;
        r = '0;
        pos = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (mask[i])
            begin
                r[pos] = v[i];
                pos++;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_signed(input logic [31:0] v, input logic [4:0] w);
        longint sv;
        longint hi;
        longint lo;
        if (w == 5'd0)
            return '0;
        sv = longint'(signed'(v));
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -(longint'(1) << (w - 1));
        if (sv > hi)
            sv = hi;
        else if (sv < lo)
            sv = lo;
        return sv[31:0];
    endfunction

    // executes one instruction on the shadow state and queues its results
    task automatic execute_instr(input instr_t it);
        logic [31:0] d_val;
        logic [31:0] s1_val;
        logic [31:0] s2_val;
        logic [31:0] t_val;
        logic [31:0] imm;
        logic [31:0] addr;
        logic [31:0] next_pc;
        result_t res;
        d_val  = model_regs[it.field_d % REG_COUNT];
        s1_val = model_regs[it.field_s1 % REG_COUNT];
        s2_val = model_regs[it.field_s2 % REG_COUNT];
        t_val  = model_regs[it.field_t % REG_COUNT];
        imm     = {{16{it.immediate[15]}}, it.immediate};
        addr    = d_val + imm;
        next_pc = model_pc + PC_STEP;
        res = '0;
        res.final_res = 1'b1;
        case (it.op)
            OP_LD:
            begin
                res.read_request   = 1'b1;
                res.access_address = addr;
                res.load_target    = it.field_s1;
                read_count++;
            end
            OP_ST:
            begin
                // misaligned store is dropped
                if (addr[1:0] == WORD_ALIGNED)
                begin
                    res.write_request  = 1'b1;
                    res.access_address = addr;
                    res.write_word     = s1_val;
                    write_count++;
                end
            end
            OP_STP:
            begin
                res.write_request  = 1'b1;
                res.access_address = addr;
                res.write_word     = s1_val;
                res.final_res      = 1'b0;
                res.new_pc         = next_pc;
                expected_results.push_back(res);
                res.access_address = addr + 32'd4;
                res.write_word     = s2_val;
                res.final_res      = 1'b1;
                write_count += 2;
            end
            OP_CLS:  model_regs[it.field_d % REG_COUNT] = count_sign_run(s1_val);
            OP_BEXT: model_regs[it.field_d % REG_COUNT] = gather_masked_bits(s1_val, s2_val);
            OP_SBIT: model_regs[it.field_d % REG_COUNT] = 32'd1 << it.field_s2;
            OP_SUB:  model_regs[it.field_s2 % REG_COUNT] = d_val - s1_val;
            OP_ADD:  model_regs[it.field_s2 % REG_COUNT] = d_val + s1_val;
            OP_ADDI: model_regs[it.field_s1 % REG_COUNT] = d_val + imm;
            OP_BEQ, OP_BNE:
            begin
                if ((d_val == t_val) == (it.op == OP_BEQ))
                begin
                    next_pc   = model_pc + (imm << 2);
                    res.taken = 1'b1;
                end
            end
            OP_J:
            begin
                next_pc   = (model_pc & JUMP_KEEP_MASK) | {4'd0, it.jump_index, 2'b00};
                res.taken = 1'b1;
            end
            OP_SSAT: model_regs[it.field_d % REG_COUNT] = clamp_signed(s1_val, it.field_s2);
            OP_LRET:
            begin
                model_regs[it.field_s1 % REG_COUNT] = it.returned_word;
                next_pc = model_pc;
            end
            default: ;
        endcase
        if (res.taken)
            taken_count++;
        model_pc   = next_pc;
        res.new_pc = next_pc;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        result_count++;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("write_request", 32'(want.write_request), 32'(got.write_request));
            check_field("read_request", 32'(want.read_request), 32'(got.read_request));
            check_field("access_address", want.access_address, got.access_address);
            check_field("write_word", want.write_word, got.write_word);
            check_field("load_target", 32'(want.load_target), 32'(got.load_target));
            check_field("taken", 32'(want.taken), 32'(got.taken));
            check_field("new_pc", want.new_pc, got.new_pc);
            check_field("final_res", 32'(want.final_res), 32'(got.final_res));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result(result_ch.data);
    end

    // result side back-pressure
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    task automatic send_instr(input instr_t it);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= it;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
        execute_instr(it);
        instr_count++;
    endtask

    function automatic instr_t make_instr(input logic [3:0] op, input logic [4:0] d,
                                          input logic [4:0] s1, input logic [4:0] s2,
                                          input logic [4:0] t, input logic [15:0] imm,
                                          input logic [25:0] jidx, input logic [31:0] ret);
        instr_t it;
        it.op            = op;
        it.field_d       = d;
        it.field_s1      = s1;
        it.field_s2      = s2;
        it.field_t       = t;
        it.immediate     = imm;
        it.jump_index    = jidx;
        it.returned_word = ret;
        return it;
    endfunction

    task automatic test_arith_and_bits();
        send_instr(make_instr(OP_SBIT, 5'd1, 5'd0, 5'd31, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_SBIT, 5'd2, 5'd0, 5'd0, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_ADDI, 5'd0, 5'd3, 5'd0, 5'd0, 16'h8000, '0, '0));
        send_instr(make_instr(OP_ADDI, 5'd0, 5'd4, 5'd0, 5'd0, 16'h7FFF, '0, '0));
        send_instr(make_instr(OP_ADD, 5'd1, 5'd3, 5'd5, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_SUB, 5'd0, 5'd2, 5'd6, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_CLS, 5'd7, 5'd6, 5'd0, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_CLS, 5'd8, 5'd4, 5'd0, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_BEXT, 5'd9, 5'd6, 5'd3, 5'd0, 16'h0000, '0, '0));
        // zero width saturates to zero, the widest width of 31 bits clamps the most negative value
        send_instr(make_instr(OP_SSAT, 5'd10, 5'd1, 5'd0, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_SSAT, 5'd11, 5'd1, 5'd31, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_SSAT, 5'd12, 5'd4, 5'd5, 5'd0, 16'h0000, '0, '0));
        send_instr(make_instr(OP_SSAT, 5'd13, 5'd6, 5'd1, 5'd0, 16'h0000, '0, '0));
    endtask

    task automatic test_memory_ops();
        send_instr(make_instr(OP_LD, 5'd4, 5'd31, 5'd0, 5'd0, 16'hFFFF, '0, '0));
        send_instr(make_instr(OP_LRET, 5'd0, 5'd31, 5'd0, 5'd0, 16'h0000, '0, 32'hFFFF_FFFF));
        send_instr(make_instr(OP_ST, 5'd0, 5'd6, 5'd0, 5'd0, 16'h0004, '0, '0));
        send_instr(make_instr(OP_ST, 5'd0, 5'd6, 5'd0, 5'd0, 16'h0001, '0, '0));
        // pair store goes out even when misaligned
        send_instr(make_instr(OP_STP, 5'd2, 5'd31, 5'd1, 5'd0, 16'h0001, '0, '0));
    endtask

    task automatic test_branches_and_spares();
        send_instr(make_instr(OP_BEQ, 5'd0, 5'd0, 5'd0, 5'd0, 16'h8000, '0, '0));
        send_instr(make_instr(OP_BNE, 5'd0, 5'd0, 5'd0, 5'd0, 16'h7FFF, '0, '0));
        send_instr(make_instr(OP_BNE, 5'd1, 5'd0, 5'd0, 5'd2, 16'h7FFF, '0, '0));
        send_instr(make_instr(OP_BEQ, 5'd1, 5'd0, 5'd0, 5'd2, 16'h0010, '0, '0));
        send_instr(make_instr(OP_J, 5'd0, 5'd0, 5'd0, 5'd0, 16'h0000, 26'h3FF_FFFF, '0));
        send_instr(make_instr(OP_SPARE_A, 5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF, '0, '0));
        send_instr(make_instr(OP_SPARE_B, 5'd1, 5'd2, 5'd3, 5'd4, 16'h1234, '0, '0));
    endtask

    // mostly a handful of registers so results feed straight into the next instruction
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom);
        return 5'($urandom_range(0, 7));
    endfunction

    task automatic random_instr(output instr_t it);
        it.op            = 4'($urandom_range(0, 13));
        it.field_d       = pick_reg();
        it.field_s1      = pick_reg();
        it.field_s2      = pick_reg();
        it.field_t       = pick_reg();
        it.immediate     = 16'($urandom);
        it.jump_index    = 26'($urandom);
        it.returned_word = $urandom;
        if ($urandom_range(0, 3) == 0)
            it.immediate = 16'($urandom_range(0, 31)) - 16'd16;
        if ($urandom_range(0, 49) == 0)
            it.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        if (it.op == OP_LD)
        begin
            open_loads.push_back(it.field_s1);
            if (open_loads.size() > 8)
                void'(open_loads.pop_front());
        end
        else if (open_loads.size() != 0 && $urandom_range(0, 2) == 0)
        begin
            // complete an outstanding load into its target register
            it.op       = OP_LRET;
            it.field_s1 = open_loads.pop_front();
        end
        if ((it.op == OP_BEQ || it.op == OP_BNE) && $urandom_range(0, 1) == 0)
            it.field_t = it.field_d;
    endtask

    task automatic test_random_stream(input int unsigned count);
        instr_t it;
        repeat (count)
        begin
            random_instr(it);
            send_instr(it);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        instr_ch.valid <= 1'b0;
        instr_ch.data  <= '0;
        gaps_on = 1'b1;
        foreach (model_regs[i])
            model_regs[i] = '0;
        model_pc = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_arith_and_bits();
        test_memory_ops();
        test_branches_and_spares();
        test_random_stream(1050);
        gaps_on = 1'b0;
        test_random_stream(330);

        instr_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("executed %0d instructions giving %0d results", instr_count, result_count);
        $display("memory reads %0d, word writes %0d, taken branches and jumps %0d",
                 read_count, write_count, taken_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timed out with %0d results outstanding", $time,
                 expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
